// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the stroke line rasteriser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SLR_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SLR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/slr_pkg.sv =====
// ---------------------------------------------------------------------------
// slr_pkg
// Shared constants, codes and controller/datapath structures of the stroke
// line rasteriser.
// ---------------------------------------------------------------------------
package slr_pkg;

   localparam int MAX_SIDE   = 32;
   localparam int MAX_STEPS  = 64;
   localparam int STEP_W     = 7;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Screen coordinate, delta, walk accumulator and increment widths.
   localparam int CW = 23;
   localparam int DW = 24;
   localparam int AW = 25;
   localparam int IW = 10;

   // Shared divider.
   localparam int DIV_NW = 30;
   localparam int DIV_DW = 22;
   localparam int DIV_CW = 5;

   localparam logic [DIV_CW-1:0] ITER_SCREEN = 5'd17;
   localparam logic [DIV_CW-1:0] ITER_TINC   = 5'd9;
   localparam logic [DIV_CW-1:0] ITER_SLOPE  = 5'd30;

   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_RANGE      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_RANGE      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd4;

   // Divider operations, in the order the controller runs them.
   localparam logic [2:0] OP_SX    = 3'd0;
   localparam logic [2:0] OP_SY    = 3'd1;
   localparam logic [2:0] OP_EX    = 3'd2;
   localparam logic [2:0] OP_EY    = 3'd3;
   localparam logic [2:0] OP_TINC  = 3'd4;
   localparam logic [2:0] OP_SLOPE = 3'd5;

   typedef struct packed {
      logic       store_point;
      logic       latch_point;
      logic       skip_point;
      logic       div_start;
      logic [2:0] div_op;
      logic       post;
      logic       delta;
      logic       colour;
      logic       walk_init;
      logic       walk_en;
      logic       flush;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic start_stroke;
      logic drawable;
      logic div_done;
      logic walk_last;
      logic flush_ok;
   } status_type;

endpackage

// ===== rtl/slr_div.sv =====
// ---------------------------------------------------------------------------
// slr_div
// Shared restoring divider, one quotient bit per cycle, variable length.
// ---------------------------------------------------------------------------
module slr_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [slr_pkg::DIV_NW-1:0]  dividend,
   input  logic [slr_pkg::DIV_DW-1:0]  divisor,
   input  logic [slr_pkg::DIV_CW-1:0]  iters,
   output logic                        busy,
   output logic                        done,
   output logic [slr_pkg::DIV_NW-1:0]  quotient
);
   import slr_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_NW-1:0] quo_ff, quo_in;
   logic [DIV_DW+1:0] trial;

   // The dividend is left aligned so that exactly iters steps consume it.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      trial   = (DIV_DW+2)'({rem_ff, quo_ff[DIV_NW-1]}) - (DIV_DW+2)'(divisor);
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = iters;
         rem_in  = '0;
         quo_in  = dividend << (DIV_CW'(DIV_NW) - iters);
      end else if (busy_ff) begin
         if (!trial[DIV_DW+1]) begin
            rem_in = trial[DIV_DW-1:0];
            quo_in = {quo_ff[DIV_NW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DIV_DW-2:0], quo_ff[DIV_NW-1]};
            quo_in = {quo_ff[DIV_NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/slr_ctrl.sv =====
// ---------------------------------------------------------------------------
// slr_ctrl
// Sequencer: runs the divisions, colour and line walk of one segment.
// ---------------------------------------------------------------------------
module slr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  slr_pkg::status_type  status,
   output slr_pkg::cmd_type     cmd
);
   import slr_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DLOAD  = 4'd1;
   localparam logic [3:0] S_DWAIT  = 4'd2;
   localparam logic [3:0] S_POST   = 4'd3;
   localparam logic [3:0] S_DELTA  = 4'd4;
   localparam logic [3:0] S_COLOUR = 4'd5;
   localparam logic [3:0] S_WINIT  = 4'd6;
   localparam logic [3:0] S_WALK   = 4'd7;
   localparam logic [3:0] S_FLUSH  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [2:0] op_ff, op_in;

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      cmd        = '0;
      cmd.div_op = op_ff;
      req_tready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (status.start_stroke) begin
                  cmd.store_point = 1'b1;
               end else if (status.drawable) begin
                  cmd.latch_point = 1'b1;
                  op_in           = OP_SX;
                  state_in        = S_DLOAD;
               end else begin
                  cmd.skip_point = 1'b1;
               end
            end
         end
         S_DLOAD: begin
            cmd.div_start = 1'b1;
            state_in      = S_DWAIT;
         end
         S_DWAIT: begin
            if (status.div_done) state_in = S_POST;
         end
         S_POST: begin
            cmd.post = 1'b1;
            unique case (op_ff)
               OP_SX:    begin op_in = OP_SY; state_in = S_DLOAD; end
               OP_SY:    begin op_in = OP_EX; state_in = S_DLOAD; end
               OP_EX:    begin op_in = OP_EY; state_in = S_DLOAD; end
               OP_EY:    state_in = S_DELTA;
               OP_TINC:  state_in = S_COLOUR;
               OP_SLOPE: state_in = S_WINIT;
               default:  state_in = S_IDLE;
            endcase
         end
         S_DELTA: begin
            cmd.delta = 1'b1;
            op_in     = OP_TINC;
            state_in  = S_DLOAD;
         end
         S_COLOUR: begin
            cmd.colour = 1'b1;
            op_in      = OP_SLOPE;
            state_in   = S_DLOAD;
         end
         S_WINIT: begin
            cmd.walk_init = 1'b1;
            state_in      = S_WALK;
         end
         S_WALK: begin
            cmd.walk_en = 1'b1;
            if (status.walk_last) state_in = S_FLUSH;
         end
         S_FLUSH: begin
            if (status.flush_ok) begin
               cmd.flush  = 1'b1;
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_SX;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

endmodule

// ===== rtl/slr_dp.sv =====
// ---------------------------------------------------------------------------
// slr_dp
// Datapath: configuration, stroke state, screen mapping, colour, line walk
// and the result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module slr_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [slr_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tuser,
   input  logic                            csr_we,
   input  logic [slr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [slr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  slr_pkg::cmd_type                cmd,
   output slr_pkg::status_type             status,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [slr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast
);
   import slr_pkg::*;

   // Returns {in_bounds, coordinate} for a Q8 position rounded half up,
   // truncating toward zero as the mapping does.
   function automatic logic [5:0] pix_eval(input logic [AW-1:0] acc,
                                           input logic [5:0] side);
      logic [AW-1:0] s;
      logic          inb;
      logic [4:0]    pos;
      begin
         s = acc + AW'(128);
         if (!s[AW-1]) begin
            inb = s[AW-1:8] < (AW-8)'(side);
            pos = s[12:8];
         end else begin
            inb = (&s[AW-1:8]) && (s[7:0] != 8'd0) && (side != 6'd0);
            pos = 5'd0;
         end
         pix_eval = {inb, pos};
      end
   endfunction

   // Configuration registers.
   logic [8:0]  count_ff, count_in;
   logic [15:0] xr_ff, xr_in, yr_ff, yr_in;
   logic [5:0]  w_ff, w_in, h_ff, h_in;

   // Stroke state.
   logic signed [7:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [7:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [7:0]        seg_ff, seg_in;
   logic              have_ff, have_in;

   // Segment set-up.
   logic signed [CW-1:0] sx_ff, sx_in, sy_ff, sy_in, ex_ff, ex_in, ey_ff, ey_in;
   logic signed [DW-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [7:0]           t_ff, t_in;
   logic [7:0]           r_ff, r_in, g_ff, g_in, b_ff, b_in;
   logic signed [IW-1:0] minc_ff, minc_in, incx_ff, incx_in, incy_ff, incy_in;

   // Walk and output.
   logic [AW-1:0]         accx_ff, accx_in, accy_ff, accy_in;
   logic [STEP_W-1:0]     left_ff, left_in;
   logic                  pend_v_ff, pend_v_in;
   logic [4:0]            pend_x_ff, pend_x_in, pend_y_ff, pend_y_in;
   logic                  rsp_v_ff, rsp_v_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Divider interface.
   logic [DIV_NW-1:0] div_dividend, div_quo;
   logic [DIV_DW-1:0] div_divisor;
   logic [DIV_CW-1:0] div_iters;
   logic              div_busy, div_done;

   logic signed [8:0]  src_v;
   logic               src_neg;
   logic [7:0]         src_mag;
   logic               x_op;
   logic [5:0]         w_side, h_side, side;
   logic [12:0]        half;
   logic [15:0]        rng;
   logic [29:0]        scr_prod;
   logic [CW-1:0]      scr_c;
   logic [16:0]        t_prod;
   logic [DW-1:0]      dx_mag, dy_mag;
   logic               major_x;
   logic [21:0]        maj_mag, min_mag;
   logic               min_neg;
   logic signed [DW-1:0] dmaj;
   logic [AW-1:0]      dmaj_r, dmaj_abs;
   logic [16:0]        len_mag;
   logic signed [IW-1:0] maj_inc, q_signed;
   logic [7:0]         lt;
   logic [8:0]         inv;
   logic [16:0]        col_a, col_b;
   logic [5:0]         cand_x, cand_y;
   logic               cand_inb, out_free, advance, out_load, out_last;
   logic [4:0]         out_x, out_y;

   assign w_side   = (w_ff > 6'(MAX_SIDE)) ? 6'(MAX_SIDE) : w_ff;
   assign h_side   = (h_ff > 6'(MAX_SIDE)) ? 6'(MAX_SIDE) : h_ff;

   // Source of the screen mapping; y is negated before mapping.
   always_comb begin
      unique case (cmd.div_op)
         OP_SX:   src_v = {prev_x_ff[7], prev_x_ff};
         OP_SY:   src_v = -$signed({prev_y_ff[7], prev_y_ff});
         OP_EX:   src_v = {cur_x_ff[7], cur_x_ff};
         default: src_v = -$signed({cur_y_ff[7], cur_y_ff});
      endcase
   end

   assign src_neg = src_v[8];
   assign src_mag = src_neg ? 8'(-src_v) : src_v[7:0];
   assign x_op    = (cmd.div_op == OP_SX) || (cmd.div_op == OP_EX);
   assign side    = x_op ? w_side : h_side;
   assign half    = {side, 7'd0};
   assign rng     = x_op ? xr_ff : yr_ff;

   assign dx_mag  = dx_ff[DW-1] ? DW'(-dx_ff) : dx_ff;
   assign dy_mag  = dy_ff[DW-1] ? DW'(-dy_ff) : dy_ff;
   assign major_x = dx_mag > dy_mag;
   assign maj_mag = major_x ? dx_mag[21:0] : dy_mag[21:0];
   assign min_mag = major_x ? dy_mag[21:0] : dx_mag[21:0];
   assign min_neg = major_x ? dy_ff[DW-1] : dx_ff[DW-1];
   assign dmaj    = major_x ? dx_ff : dy_ff;

   // Divider operands: the mapping divides |v|*512 by the range, the colour
   // step is 256/count, the slope is |minor|*256/|major|.
   always_comb begin
      if (cmd.div_op == OP_TINC) begin
         div_dividend = DIV_NW'(256);
         div_divisor  = (count_ff == 9'd0) ? DIV_DW'(1) : DIV_DW'(count_ff);
         div_iters    = ITER_TINC;
      end else if (cmd.div_op == OP_SLOPE) begin
         div_dividend = {min_mag, 8'd0};
         div_divisor  = (maj_mag == 22'd0) ? DIV_DW'(1) : maj_mag;
         div_iters    = ITER_SLOPE;
      end else begin
         div_dividend = DIV_NW'({src_mag, 9'd0});
         div_divisor  = (rng == 16'd0) ? DIV_DW'(1) : DIV_DW'(rng);
         div_iters    = ITER_SCREEN;
      end
   end

   slr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .iters    (div_iters),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign scr_prod = 30'(div_quo[16:0]) * 30'(half);
   assign scr_c    = src_neg ? CW'(half) - CW'(scr_prod[29:8])
                             : CW'(half) + CW'(scr_prod[29:8]);
   assign t_prod   = 17'(seg_ff) * 17'(div_quo[8:0]);
   assign q_signed = min_neg ? -$signed(IW'(div_quo[8:0])) : $signed(IW'(div_quo[8:0]));

   assign dmaj_r   = {dmaj[DW-1], dmaj} + AW'(128);
   assign dmaj_abs = dmaj_r[AW-1] ? AW'(-dmaj_r) : dmaj_r;
   assign len_mag  = dmaj_abs[AW-1:8];
   assign maj_inc  = (!dmaj[DW-1] && dmaj != '0) ? IW'(256) : -$signed(IW'(256));

   // Gradient: t stays below 256 on drawn segments, so lt = 2t mod 256.
   assign lt    = {t_ff[6:0], 1'b0};
   assign inv   = 9'd256 - 9'(lt);
   assign col_a = ({inv, 8'd0} - 17'(inv) + 17'd128) >> 8;
   assign col_b = ({1'b0, lt, 8'd0} - 17'(lt) + 17'd128) >> 8;

   assign cand_x   = pix_eval(accx_ff, w_side);
   assign cand_y   = pix_eval(accy_ff, h_side);
   assign cand_inb = cand_x[5] && cand_y[5];
   assign out_free = !rsp_v_ff || rsp_tready;
   assign advance  = cmd.walk_en && (!cand_inb || !pend_v_ff || out_free);

   always_comb begin
      count_in    = count_ff;
      xr_in       = xr_ff;
      yr_in       = yr_ff;
      w_in        = w_ff;
      h_in        = h_ff;
      prev_x_in   = prev_x_ff;
      prev_y_in   = prev_y_ff;
      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      seg_in      = seg_ff;
      have_in     = have_ff;
      sx_in       = sx_ff;
      sy_in       = sy_ff;
      ex_in       = ex_ff;
      ey_in       = ey_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      t_in        = t_ff;
      r_in        = r_ff;
      g_in        = g_ff;
      b_in        = b_ff;
      minc_in     = minc_ff;
      incx_in     = incx_ff;
      incy_in     = incy_ff;
      accx_in     = accx_ff;
      accy_in     = accy_ff;
      left_in     = left_ff;
      pend_v_in   = pend_v_ff;
      pend_x_in   = pend_x_ff;
      pend_y_in   = pend_y_ff;
      out_load    = 1'b0;
      out_last    = 1'b0;
      out_x       = pend_x_ff;
      out_y       = pend_y_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_POINT_COUNT:  count_in = csr_wdata[8:0];
            CSR_X_RANGE:      xr_in    = csr_wdata;
            CSR_Y_RANGE:      yr_in    = csr_wdata;
            CSR_IMAGE_WIDTH:  w_in     = csr_wdata[5:0];
            CSR_IMAGE_HEIGHT: h_in     = csr_wdata[5:0];
            default: ;
         endcase
      end

      if (cmd.store_point) begin
         prev_x_in = req_tdata[7:0];
         prev_y_in = req_tdata[15:8];
         seg_in    = 8'd0;
         have_in   = 1'b1;
      end
      if (cmd.skip_point) begin
         prev_x_in = req_tdata[7:0];
         prev_y_in = req_tdata[15:8];
         if (seg_ff != 8'hFF) seg_in = seg_ff + 8'd1;
      end
      if (cmd.latch_point) begin
         cur_x_in = req_tdata[7:0];
         cur_y_in = req_tdata[15:8];
      end
      if (cmd.finish) begin
         prev_x_in = cur_x_ff;
         prev_y_in = cur_y_ff;
         if (seg_ff != 8'hFF) seg_in = seg_ff + 8'd1;
      end

      if (cmd.post) begin
         unique case (cmd.div_op)
            OP_SX:    sx_in   = scr_c;
            OP_SY:    sy_in   = scr_c;
            OP_EX:    ex_in   = scr_c;
            OP_EY:    ey_in   = scr_c;
            OP_TINC:  t_in    = t_prod[7:0];
            OP_SLOPE: minc_in = q_signed;
            default: ;
         endcase
      end

      if (cmd.delta) begin
         dx_in = DW'(ex_ff) - DW'(sx_ff);
         dy_in = DW'(ey_ff) - DW'(sy_ff);
      end

      if (cmd.colour) begin
         if (!t_ff[7]) begin
            r_in = {~col_a[7], col_a[6:0]};
            g_in = {~col_b[7], col_b[6:0]};
            b_in = 8'h80;
         end else begin
            r_in = 8'h80;
            g_in = {~col_a[7], col_a[6:0]};
            b_in = {~col_b[7], col_b[6:0]};
         end
      end

      if (cmd.walk_init) begin
         accx_in   = AW'(sx_ff);
         accy_in   = AW'(sy_ff);
         incx_in   = major_x ? maj_inc : minc_ff;
         incy_in   = major_x ? minc_ff : maj_inc;
         left_in   = (len_mag >= 17'(MAX_STEPS - 1)) ? STEP_W'(MAX_STEPS)
                                                     : STEP_W'(len_mag) + 1'b1;
         pend_v_in = 1'b0;
      end

      // A pixel waits in the pending slot until the next in-bounds pixel or
      // the end of the segment shows whether it is the last one.
      if (advance) begin
         accx_in = accx_ff + AW'(incx_ff);
         accy_in = accy_ff + AW'(incy_ff);
         left_in = left_ff - 1'b1;
         if (cand_inb) begin
            if (pend_v_ff) out_load = 1'b1;
            pend_v_in = 1'b1;
            pend_x_in = cand_x[4:0];
            pend_y_in = cand_y[4:0];
         end
      end

      if (cmd.flush) begin
         if (pend_v_ff) begin
            out_load = 1'b1;
            out_last = 1'b1;
         end
         pend_v_in = 1'b0;
      end
   end

   always_comb begin
      rsp_v_in    = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_v_ff);
      rsp_last_in = rsp_last_ff;
      rsp_data_in = rsp_data_ff;
      if (out_load) begin
         rsp_last_in = out_last;
         rsp_data_in = {6'd0, b_ff, g_ff, r_ff, out_y, out_x};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 9'd0;
         xr_ff     <= 16'd256;
         yr_ff     <= 16'd256;
         w_ff      <= 6'd32;
         h_ff      <= 6'd32;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         seg_ff    <= '0;
         have_ff   <= 1'b0;
         left_ff   <= '0;
         pend_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         count_ff  <= count_in;
         xr_ff     <= xr_in;
         yr_ff     <= yr_in;
         w_ff      <= w_in;
         h_ff      <= h_in;
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
         seg_ff    <= seg_in;
         have_ff   <= have_in;
         left_ff   <= left_in;
         pend_v_ff <= pend_v_in;
         rsp_v_ff  <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      ex_ff       <= ex_in;
      ey_ff       <= ey_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      t_ff        <= t_in;
      r_ff        <= r_in;
      g_ff        <= g_in;
      b_ff        <= b_in;
      minc_ff     <= minc_in;
      incx_ff     <= incx_in;
      incy_ff     <= incy_in;
      accx_ff     <= accx_in;
      accy_ff     <= accy_in;
      pend_x_ff   <= pend_x_in;
      pend_y_ff   <= pend_y_in;
      rsp_last_ff <= rsp_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.start_stroke = req_tuser || !have_ff;
   assign status.drawable     = (9'(seg_ff) + 9'd1) < count_ff;
   assign status.div_done     = div_done;
   assign status.walk_last    = advance && (left_ff == STEP_W'(1));
   assign status.flush_ok     = !pend_v_ff || out_free;

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `SLR_ASSERT_IMPL(a_div_idle, cmd.div_start, !div_busy, "divider started while busy")
   `SLR_ASSERT_IMPL(a_walk_left, cmd.walk_en, left_ff != '0, "walk with no steps left")
   `SLR_ASSERT_IMPL(a_out_free, out_load, out_free, "result overwritten before taken")
   `SLR_ASSERT_NEXT(a_flush_empty, cmd.flush, !pend_v_ff, "pending pixel kept after flush")

endmodule

// ===== rtl/stroke_line_rasterizer.sv =====
// ---------------------------------------------------------------------------
// stroke_line_rasterizer
// Turns stroke points into coloured pixels along straight segments.
// ---------------------------------------------------------------------------
// Usage: each request transaction carries one stroke point (req_tdata holds
// point_x then point_y, req_tuser is first_point). A first point, or any point
// while no point is stored, only stores it. Each later point draws a segment
// from the stored point when the segment index is below point_count - 1, and
// returns its in-bounds pixels as response transactions, rsp_tlast marking
// the last pixel of the segment. A segment that lands wholly off screen gives
// no transaction at all.
// Sequence: a point that draws nothing is taken in the idle state. A drawn
// segment runs six divisions (four screen mappings, colour step, slope, each
// with load and post-processing) through one shared bit-serial divider, with
// set-up steps among them, then one DDA step per cycle while the output does
// not stall, for up to 64 steps. req_tready is high only between segments.
// Stalls: results leave through an output register behind a one-pixel pending
// slot; a stalled receiver holds the walk once both are full and a further
// in-bounds pixel is found. Reset clears the stroke state and loads the
// register defaults; configuration writes belong between segments.
// ---------------------------------------------------------------------------
module stroke_line_rasterizer (
   input  logic                            clock,
   input  logic                            reset,
   // Request: tdata [7:0] point_x, [15:8] point_y; tuser [0] first_point.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [slr_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tuser,
   // Response: tdata [4:0] pixel_x, [9:5] pixel_y, [17:10] red_value,
   // [25:18] green_value, [33:26] blue_value, [39:34] zero.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [slr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast,
   // Configuration write port.
   input  logic                            csr_we,
   input  logic [slr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [slr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import slr_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The controller sequences each segment; the datapath holds the configuration, stroke and walk state.
   slr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   slr_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
